// File: src/hkr_pkg.sv
// ----------------------------------------------------------------------------
// hkr_pkg: shared types and tables for the HID keyboard report decoder
// Holds field widths, the shift mask, the lane result type and the
// usage-code-to-ASCII lookup for the plain and the shifted key layers.
// ----------------------------------------------------------------------------
package hkr_pkg;

	localparam int KEY_W  = 8;
	localparam int CHAR_W = 7;
	localparam int MAX_SLOTS = 6;
	localparam int REPORT_W = KEY_W * (MAX_SLOTS + 1);

	localparam logic [KEY_W-1:0] SHIFT_MASK = 8'h22;

	// Result of one slot lane
	typedef struct packed {
		logic              hit;
		logic [CHAR_W-1:0] ch;
	} lane_res_t;

	// Map one usage code to ASCII; zero means no character
	function automatic logic [CHAR_W-1:0] key_char(input logic shift,
			input logic [KEY_W-1:0] code);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		if (code >= 8'h04 && code <= 8'h1D) begin
			// letters
			ch = shift ? CHAR_W'(code + 8'h3D) : CHAR_W'(code + 8'h5D);
		end else if (!shift) begin
			if (code >= 8'h1E && code <= 8'h26) begin
				ch = CHAR_W'(code + 8'h13);
			end else begin
				case (code)
					8'h27: ch = 7'h30;
					8'h28: ch = 7'h0A;
					8'h29: ch = 7'h1B;
					8'h2A: ch = 7'h08;
					8'h2B: ch = 7'h09;
					8'h2C: ch = 7'h20;
					8'h2D: ch = 7'h2D;
					8'h2E: ch = 7'h3D;
					8'h2F: ch = 7'h5B;
					8'h30: ch = 7'h5D;
					8'h31: ch = 7'h5C;
					8'h33: ch = 7'h3B;
					8'h34: ch = 7'h27;
					8'h35: ch = 7'h60;
					8'h36: ch = 7'h2C;
					8'h37: ch = 7'h2E;
					8'h38: ch = 7'h2F;
					default: ch = '0;
				endcase
			end
		end else begin
			case (code)
				8'h1E: ch = 7'h21;
				8'h1F: ch = 7'h40;
				8'h20: ch = 7'h23;
				8'h21: ch = 7'h24;
				8'h22: ch = 7'h25;
				8'h23: ch = 7'h5E;
				8'h24: ch = 7'h26;
				8'h25: ch = 7'h2A;
				8'h26: ch = 7'h28;
				8'h27: ch = 7'h29;
				8'h2D: ch = 7'h5F;
				8'h2E: ch = 7'h2B;
				8'h2F: ch = 7'h7B;
				8'h30: ch = 7'h7D;
				8'h31: ch = 7'h7C;
				8'h33: ch = 7'h3A;
				8'h34: ch = 7'h22;
				8'h35: ch = 7'h7E;
				8'h36: ch = 7'h3C;
				8'h37: ch = 7'h3E;
				8'h38: ch = 7'h3F;
				default: ch = '0;
			endcase
		end
		return ch;
	endfunction

endpackage

// File: src/hkr_lane.sv
// ----------------------------------------------------------------------------
// hkr_lane: decode of one key slot
// Checks the slot code against the previous report and looks up its
// character; flags a hit when the key is newly pressed and maps to a character.
// ----------------------------------------------------------------------------
module hkr_lane #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                                         shift,
	input  logic [hkr_pkg::KEY_W-1:0]                    code,
	input  logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0]     held_codes,
	output hkr_pkg::lane_res_t                           res
);

	logic                        held;
	logic [hkr_pkg::CHAR_W-1:0] ch;

	// Match against every key of the previous report
	always_comb begin
		held = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (held_codes[i] == code) begin
				held = 1'b1;
			end
		end
	end

	assign ch      = hkr_pkg::key_char(shift, code);
	assign res.ch  = ch;
	assign res.hit = (code != '0) && !held && (ch != '0);

endmodule

// File: src/hkr_emit.sv
// ----------------------------------------------------------------------------
// hkr_emit: merge of lane results into a character stream
// Holds the lane hits of one report and sends them out lowest slot first,
// one per cycle unless the output stalls, flagging the report's last character.
// ----------------------------------------------------------------------------
module hkr_emit #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  hkr_pkg::lane_res_t [KEY_SLOTS-1:0]      lanes,
	output logic                                    free,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [hkr_pkg::CHAR_W-1:0]              out_char,
	output logic                                    out_last
);

	logic [KEY_SLOTS-1:0]                          mask_s1;
	logic [KEY_SLOTS-1:0][hkr_pkg::CHAR_W-1:0]     char_s1;
	logic [KEY_SLOTS-1:0]                          new_mask;
	logic [KEY_SLOTS-1:0]                          pick;
	logic [KEY_SLOTS-1:0]                          rest;
	logic [hkr_pkg::CHAR_W-1:0]                    sel_char;
	logic                                          adv;

	// Gather lane hits
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			new_mask[i] = lanes[i].hit;
		end
	end

	// Pick the lowest pending slot
	assign pick = mask_s1 & (~mask_s1 + KEY_SLOTS'(1));
	assign rest = mask_s1 & ~pick;
	assign adv  = (mask_s1 != '0) && (!out_valid || out_ready);
	assign free = (mask_s1 == '0) || (adv && (rest == '0));

	always_comb begin
		sel_char = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (pick[i]) begin
				sel_char = sel_char | char_s1[i];
			end
		end
	end

	// Pending mask: load a new report or retire the slot just sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= '0;
		end else if (load) begin
			mask_s1 <= new_mask;
		end else if (adv) begin
			mask_s1 <= rest;
		end
	end

	// Hold the characters of the pending report
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				char_s1[i] <= lanes[i].ch;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_char <= sel_char;
			out_last <= (rest == '0);
		end
	end

endmodule

// File: src/hid_keyboard_report_to_ascii.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_to_ascii: HID boot keyboard report to ASCII stream
// Decodes newly pressed keys of each report into characters.
//
//  channel  dir  tdata fields (low bit up)                         tlast
//  s_       in   modifier_bits[7:0], key_slot_0..key_slot_5 [55:8]  -
//  m_       out  ascii_char[6:0], zero pad [7]                      last_of_report
//
// One lane per key slot decodes all slots of a report in the accept cycle.
// A report with new characters sends one output beat per character; a report
// with none sends nothing.
// A new report is taken as the final character of the previous one enters
// the output register; a stalled output holds s_tready low until then.
// Reset clears the previous-report keys to zero.
// ----------------------------------------------------------------------------
module hid_keyboard_report_to_ascii #(
	parameter int KEY_SLOTS = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [hkr_pkg::REPORT_W-1:0]   s_tdata,  // modifier_bits, key_slot_0..5
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,  // ascii_char, zero pad
	output logic                           m_tlast
);

	logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0]  codes;
	logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0]  prev_q;
	hkr_pkg::lane_res_t [KEY_SLOTS-1:0]        lanes;
	logic                                      shift;
	logic                                      accept;
	logic                                      any_hit;
	logic                                      free;
	logic [hkr_pkg::CHAR_W-1:0]                out_char;

	// Unpack the report
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			codes[i] = s_tdata[hkr_pkg::KEY_W*(i+1) +: hkr_pkg::KEY_W];
		end
	end

	assign shift = (s_tdata[hkr_pkg::KEY_W-1:0] & hkr_pkg::SHIFT_MASK) != '0;

	// One decode lane per slot
	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
		hkr_lane #(
			.KEY_SLOTS(KEY_SLOTS)
		) u_lane (
			.shift     (shift),
			.code      (codes[g]),
			.held_codes(prev_q),
			.res       (lanes[g])
		);
	end

	always_comb begin
		any_hit = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			any_hit = any_hit | lanes[i].hit;
		end
	end

	assign s_tready = free;
	assign accept   = s_tvalid && s_tready;

	// Store the accepted report as the previous one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept) begin
			prev_q <= codes;
		end
	end

	hkr_emit #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && any_hit),
		.lanes    (lanes),
		.free     (free),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_char (out_char),
		.out_last (m_tlast)
	);

	assign m_tdata = {1'b0, out_char};

endmodule
